FILE: src/prd_pkg.sv
// ----------------------------------------------------------------------------
// prd_pkg
// Shared widths, codes and types of the pedal report event decoder.
// ----------------------------------------------------------------------------
package prd_pkg;

   // Running byte sum width (8 to 32)
   localparam int SUM_W       = 16;
   localparam int BYTE_W      = 8;
   localparam int CODE_W      = 16;
   localparam int PEDAL_W     = 2;
   localparam int ACT_W       = 2;
   // Wide enough for any byte sum and for the sum of all three codes
   localparam int CMP_W       = ((SUM_W > CODE_W) ? SUM_W : CODE_W) + 2;

   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = CODE_W;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_W + 1;

   localparam int MAX_EVENTS  = 7;
   localparam int EIDX_W      = $clog2(MAX_EVENTS);
   localparam int ECNT_W      = $clog2(MAX_EVENTS + 1);

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_MODE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LEFT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MIDDLE = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_RIGHT  = 2'd3;

   localparam logic MODE_ON_OFF   = 1'b0;
   localparam logic MODE_OVERRIDE = 1'b1;

   // Active pedal coding
   localparam logic [ACT_W-1:0] ACT_NONE   = 2'd0;
   localparam logic [ACT_W-1:0] ACT_LEFT   = 2'd1;
   localparam logic [ACT_W-1:0] ACT_MIDDLE = 2'd2;
   localparam logic [ACT_W-1:0] ACT_RIGHT  = 2'd3;

   // Event pedal coding
   localparam logic [PEDAL_W-1:0] PEDAL_LEFT   = 2'd0;
   localparam logic [PEDAL_W-1:0] PEDAL_MIDDLE = 2'd1;
   localparam logic [PEDAL_W-1:0] PEDAL_RIGHT  = 2'd2;

   typedef struct packed {
      logic              mode;
      logic [CODE_W-1:0] left_code;
      logic [CODE_W-1:0] middle_code;
      logic [CODE_W-1:0] right_code;
   } cfg_type;

   typedef struct packed {
      logic [PEDAL_W-1:0] pedal;
      logic               pressed;
   } pedal_event_type;

endpackage

FILE: src/prd_req_if.sv
// ----------------------------------------------------------------------------
// prd_req_if
// Report byte channel: valid/ready with one report byte per transfer.
// ----------------------------------------------------------------------------
interface prd_req_if
   import prd_pkg::*;
   ;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] report_byte;
   logic              end_of_report;

   modport source (output valid, report_byte, end_of_report, input ready);
   modport sink   (input valid, report_byte, end_of_report, output ready);
endinterface

FILE: src/prd_rsp_if.sv
// ----------------------------------------------------------------------------
// prd_rsp_if
// Pedal event channel: valid/ready with one event per transfer.
// ----------------------------------------------------------------------------
interface prd_rsp_if
   import prd_pkg::*;
   ;
   logic               valid;
   logic               ready;
   logic [PEDAL_W-1:0] pedal;
   logic               pressed;
   logic               last_event;

   modport source (output valid, pedal, pressed, last_event, input ready);
   modport sink   (input valid, pedal, pressed, last_event, output ready);
endinterface

FILE: src/prd_front.sv
// ----------------------------------------------------------------------------
// prd_front
// Accepts report bytes, keeps the wrapping byte sum and hands each finished
// report sum to the report queue.
// ----------------------------------------------------------------------------
module prd_front
   import prd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   prd_req_if.sink          req_bus,
   output logic             push_valid,
   output logic [SUM_W-1:0] push_code,
   input  logic             push_ready
);

   logic [SUM_W-1:0] sum_ff;
   logic [SUM_W-1:0] sum_in;
   logic [SUM_W-1:0] sum_next;
   logic             accept;

   assign req_bus.ready = push_ready;
   assign accept        = req_bus.valid && req_bus.ready;
   assign sum_next      = sum_ff + SUM_W'(req_bus.report_byte);

   assign push_valid = accept && req_bus.end_of_report;
   assign push_code  = sum_next;

   always_comb begin
      sum_in = sum_ff;
      if (accept) begin
         // clear at report end, accumulate otherwise
         sum_in = req_bus.end_of_report ? '0 : sum_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
   end

endmodule

FILE: src/prd_queue.sv
// ----------------------------------------------------------------------------
// prd_queue
// Short FIFO of finished report sums between the front and the decoder.
// ----------------------------------------------------------------------------
module prd_queue
   import prd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  logic [SUM_W-1:0] push_code,
   output logic             push_ready,
   input  logic             pop,
   output logic             head_valid,
   output logic [SUM_W-1:0] head_code
);

   logic [SUM_W-1:0]  slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff,  count_in;
   logic              do_push;
   logic              do_pop;

   assign push_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_code  = slot_ff[rd_ptr_ff];

   assign do_push = push_valid && push_ready;
   assign do_pop  = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_code;
      end
   end

endmodule

FILE: src/prd_back.sv
// ----------------------------------------------------------------------------
// prd_back
// Decodes one report sum into its burst of release and press events, keeps
// the active pedal and sends the burst out one event per transfer.
// ----------------------------------------------------------------------------
module prd_back
   import prd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  logic             head_valid,
   input  logic [SUM_W-1:0] head_code,
   output logic             pop,
   prd_rsp_if.source        rsp_bus
);

   pedal_event_type    ev_buf_ff [MAX_EVENTS];
   logic [EIDX_W-1:0]  rd_ff,  rd_in;
   logic [ECNT_W-1:0]  rem_ff, rem_in;
   logic [ACT_W-1:0]   act_ff, act_in;

   pedal_event_type    dec_ev [MAX_EVENTS];
   logic [ECNT_W-1:0]  dec_n;
   logic [ACT_W-1:0]   dec_act;
   logic [CMP_W-1:0]   c;
   logic [CMP_W-1:0]   l, m, r;
   logic [CMP_W-1:0]   lm, lr, mr, lmr;
   logic               take;
   logic               xfer;
   logic               load;

   function automatic pedal_event_type mk_ev(logic [PEDAL_W-1:0] pedal, logic pressed);
      pedal_event_type e;
      e.pedal   = pedal;
      e.pressed = pressed;
      return e;
   endfunction

   assign l   = CMP_W'(cfg.left_code);
   assign m   = CMP_W'(cfg.middle_code);
   assign r   = CMP_W'(cfg.right_code);
   assign lm  = l + m;
   assign lr  = l + r;
   assign mr  = m + r;
   assign lmr = lm + r;

   // Event list of the report at the queue head
   always_comb begin
      for (int i = 0; i < MAX_EVENTS; i++) begin
         dec_ev[i] = '0;
      end
      dec_n   = '0;
      dec_act = act_ff;
      c       = CMP_W'(head_code);
      take    = 1'b0;
      if (cfg.mode == MODE_ON_OFF) begin
         if (act_ff != ACT_NONE) begin
            dec_ev[EIDX_W'(dec_n)] = mk_ev(PEDAL_W'(act_ff - 1'b1), 1'b0);
            dec_n = dec_n + 1'b1;
         end
         take = (c == '0) || (c == l) || (c == m) || (c == r);
      end else begin
         // pair checks run in order, each on the sum left by the one before
         if (c == lm) begin
            if (dec_act == ACT_LEFT) begin
               dec_ev[EIDX_W'(dec_n)] = mk_ev(PEDAL_LEFT, 1'b0);
               dec_act = ACT_MIDDLE;
               c = m;
            end else begin
               dec_ev[EIDX_W'(dec_n)] = mk_ev(PEDAL_MIDDLE, 1'b0);
               dec_act = ACT_LEFT;
               c = l;
            end
            dec_n = dec_n + 1'b1;
         end
         if (c == lr) begin
            if (dec_act == ACT_LEFT) begin
               dec_ev[EIDX_W'(dec_n)] = mk_ev(PEDAL_LEFT, 1'b0);
               dec_act = ACT_RIGHT;
               c = r;
            end else begin
               dec_ev[EIDX_W'(dec_n)] = mk_ev(PEDAL_RIGHT, 1'b0);
               dec_act = ACT_LEFT;
               c = l;
            end
            dec_n = dec_n + 1'b1;
         end
         if (c == mr) begin
            if (dec_act == ACT_MIDDLE) begin
               dec_ev[EIDX_W'(dec_n)] = mk_ev(PEDAL_MIDDLE, 1'b0);
               dec_act = ACT_RIGHT;
               c = r;
            end else begin
               dec_ev[EIDX_W'(dec_n)] = mk_ev(PEDAL_RIGHT, 1'b0);
               dec_act = ACT_MIDDLE;
               c = m;
            end
            dec_n = dec_n + 1'b1;
         end
         // release the pedal that was active when the report began
         if (act_ff != ACT_NONE) begin
            dec_ev[EIDX_W'(dec_n)] = mk_ev(PEDAL_W'(act_ff - 1'b1), 1'b0);
            dec_n = dec_n + 1'b1;
         end
         take = (c != lmr);
      end
      if (take) begin
         if (c == l) begin
            dec_ev[EIDX_W'(dec_n)] = mk_ev(PEDAL_LEFT, 1'b1);
            dec_n   = dec_n + 1'b1;
            dec_act = ACT_LEFT;
         end
         if (c == m) begin
            dec_ev[EIDX_W'(dec_n)] = mk_ev(PEDAL_MIDDLE, 1'b1);
            dec_n   = dec_n + 1'b1;
            dec_act = ACT_MIDDLE;
         end
         if (c == r) begin
            dec_ev[EIDX_W'(dec_n)] = mk_ev(PEDAL_RIGHT, 1'b1);
            dec_n   = dec_n + 1'b1;
            dec_act = ACT_RIGHT;
         end
         if (c == '0) begin
            dec_act = ACT_NONE;
         end
      end
   end

   assign rsp_bus.valid      = (rem_ff != '0);
   assign rsp_bus.pedal      = ev_buf_ff[rd_ff].pedal;
   assign rsp_bus.pressed    = ev_buf_ff[rd_ff].pressed;
   assign rsp_bus.last_event = (rem_ff == ECNT_W'(1));

   assign xfer = rsp_bus.valid && rsp_bus.ready;
   // take the next report once the current burst is drained or drains now
   assign load = head_valid && ((rem_ff == '0) || (xfer && rem_ff == ECNT_W'(1)));
   assign pop  = load;

   always_comb begin
      rd_in  = rd_ff;
      rem_in = rem_ff;
      act_in = act_ff;
      if (load) begin
         rd_in  = '0;
         rem_in = dec_n;
         act_in = dec_act;
      end else if (xfer) begin
         rd_in  = rd_ff + 1'b1;
         rem_in = rem_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff  <= '0;
         rem_ff <= '0;
         act_ff <= ACT_NONE;
      end else begin
         rd_ff  <= rd_in;
         rem_ff <= rem_in;
         act_ff <= act_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         for (int i = 0; i < MAX_EVENTS; i++) begin
            ev_buf_ff[i] <= dec_ev[i];
         end
      end
   end

endmodule

FILE: src/pedal_report_event_decoder_core.sv
// ----------------------------------------------------------------------------
// pedal_report_event_decoder_core
// Three-pedal report decoder: report bytes in, pedal press/release events out.
// ----------------------------------------------------------------------------
// One report byte is taken every cycle while the four-entry report queue has
// room; the front keeps the wrapping byte sum and queues the sum on the last
// byte. The decoder turns a queued sum combinationally into its zero to seven
// events and sends them one event per cycle while the receiver is ready; the
// first event of a report comes at the earliest after its sum passes the
// queue and event buffer registers. A report holds the decoder until its
// events transfer, or only for its load when it has none, and the next report
// loads in the cycle the last event transfers. Events of a report come in
// order, the final one marked by last_event. Configuration is taken one register
// per cycle on csr_we and must only change while no report is in flight.
// ----------------------------------------------------------------------------
module pedal_report_event_decoder_core
   import prd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   prd_req_if.sink               req_bus,
   prd_rsp_if.source             rsp_bus,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type          cfg_ff, cfg_in;
   logic             push_valid;
   logic [SUM_W-1:0] push_code;
   logic             push_ready;
   logic             pop;
   logic             head_valid;
   logic [SUM_W-1:0] head_code;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_MODE:   cfg_in.mode        = csr_wdata[0];
            REG_LEFT:   cfg_in.left_code   = csr_wdata[CODE_W-1:0];
            REG_MIDDLE: cfg_in.middle_code = csr_wdata[CODE_W-1:0];
            REG_RIGHT:  cfg_in.right_code  = csr_wdata[CODE_W-1:0];
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode        <= MODE_ON_OFF;
         cfg_ff.left_code   <= CODE_W'(1);
         cfg_ff.middle_code <= CODE_W'(2);
         cfg_ff.right_code  <= CODE_W'(4);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   prd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .push_valid (push_valid),
      .push_code  (push_code),
      .push_ready (push_ready)
   );

   prd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_code  (push_code),
      .push_ready (push_ready),
      .pop        (pop),
      .head_valid (head_valid),
      .head_code  (head_code)
   );

   prd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (head_valid),
      .head_code  (head_code),
      .pop        (pop),
      .rsp_bus    (rsp_bus)
   );

endmodule

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pedal report event decoder core.
// Report bytes go in over a valid/ready channel. A local decoder predicts
// the press and release events of every finished report, and each event
// that comes out is compared in order against that prediction. Directed
// reports cover both modes, shared and zero codes, and wide codes. A fixed
// report sequence then runs under one long receiver hold-off, and random
// reports under several idle and stall patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top
   import prd_pkg::*;
   ;

   localparam int QUIET_LIMIT = 3000;
   localparam int SETTLE_CYCLES = 12;

   typedef struct {
      logic [PEDAL_W-1:0] pedal;
      logic               pressed;
      logic               last_event;
   } tb_event_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   prd_req_if req_bus ();
   prd_rsp_if rsp_bus ();

   pedal_report_event_decoder_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Decoder shadow state
   cfg_type          shadow_cfg;
   logic [SUM_W-1:0] running_sum;
   logic [ACT_W-1:0] held_pedal;
   logic [ACT_W-1:0] override_prior;
   tb_event_type     burst[$];
   tb_event_type     events_due[$];

   int unsigned mismatch_count = 0;
   int unsigned bytes_sent = 0;
   int          sender_idle_pct = 0;
   int          receiver_stall_pct = 0;
   int          hold_len = 0;
   int          hold_serial = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Event prediction
   // ------------------------------------------------------------------------
   task automatic emit_event(input logic [ACT_W-1:0] who, input logic press);
      tb_event_type e;
      if (burst.size() >= MAX_EVENTS) return;
      case (who)
         ACT_LEFT:   e.pedal = PEDAL_LEFT;
         ACT_MIDDLE: e.pedal = PEDAL_MIDDLE;
         ACT_RIGHT:  e.pedal = PEDAL_RIGHT;
         default:    return;
      endcase
      e.pressed    = press;
      e.last_event = 1'b0;
      burst.push_back(e);
   endtask

   task automatic apply_presses(input logic [CMP_W-1:0] code);
      if (code == CMP_W'(shadow_cfg.left_code)) begin
         held_pedal = ACT_LEFT;
         emit_event(ACT_LEFT, 1'b1);
      end
      if (code == CMP_W'(shadow_cfg.middle_code)) begin
         held_pedal = ACT_MIDDLE;
         emit_event(ACT_MIDDLE, 1'b1);
      end
      if (code == CMP_W'(shadow_cfg.right_code)) begin
         held_pedal = ACT_RIGHT;
         emit_event(ACT_RIGHT, 1'b1);
      end
      if (code == '0) held_pedal = ACT_NONE;
   endtask

   task automatic decode_report_byte(input logic [BYTE_W-1:0] value, input logic last);
      logic [CMP_W-1:0] code;
      logic [CMP_W-1:0] l;
      logic [CMP_W-1:0] m;
      logic [CMP_W-1:0] r;
      running_sum = running_sum + SUM_W'(value);
      if (!last) return;
      burst.delete();
      code = CMP_W'(running_sum);
      l = CMP_W'(shadow_cfg.left_code);
      m = CMP_W'(shadow_cfg.middle_code);
      r = CMP_W'(shadow_cfg.right_code);
      if (shadow_cfg.mode == MODE_ON_OFF) begin
         emit_event(held_pedal, 1'b0);
         if (code == '0 || code == l || code == m || code == r) apply_presses(code);
      end else begin
         override_prior = held_pedal;
         // Pair sums at full width; each check sees the code left by the one before
         if (code == l + m) begin
            if (held_pedal == ACT_LEFT) begin
               emit_event(ACT_LEFT, 1'b0);
               held_pedal = ACT_MIDDLE;
               code = code - l;
            end else begin
               emit_event(ACT_MIDDLE, 1'b0);
               held_pedal = ACT_LEFT;
               code = code - m;
            end
         end
         if (code == l + r) begin
            if (held_pedal == ACT_LEFT) begin
               emit_event(ACT_LEFT, 1'b0);
               held_pedal = ACT_RIGHT;
               code = code - l;
            end else begin
               emit_event(ACT_RIGHT, 1'b0);
               held_pedal = ACT_LEFT;
               code = code - r;
            end
         end
         if (code == m + r) begin
            if (held_pedal == ACT_MIDDLE) begin
               emit_event(ACT_MIDDLE, 1'b0);
               held_pedal = ACT_RIGHT;
               code = code - m;
            end else begin
               emit_event(ACT_RIGHT, 1'b0);
               held_pedal = ACT_MIDDLE;
               code = code - r;
            end
         end
         emit_event(override_prior, 1'b0);
         if (code != l + m + r) apply_presses(code);
      end
      running_sum = '0;
      foreach (burst[k]) begin
         burst[k].last_event = (k == burst.size() - 1);
         events_due.push_back(burst[k]);
      end
   endtask

   // ------------------------------------------------------------------------
   // Driving
   // ------------------------------------------------------------------------
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         REG_MODE:   shadow_cfg.mode        = data[0];
         REG_LEFT:   shadow_cfg.left_code   = data;
         REG_MIDDLE: shadow_cfg.middle_code = data;
         REG_RIGHT:  shadow_cfg.right_code  = data;
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic mode, input logic [CODE_W-1:0] l,
                            input logic [CODE_W-1:0] m, input logic [CODE_W-1:0] r);
      write_reg(REG_MODE, CSR_DATA_W'(mode));
      write_reg(REG_LEFT, l);
      write_reg(REG_MIDDLE, m);
      write_reg(REG_RIGHT, r);
   endtask

   task automatic send_byte(input logic [BYTE_W-1:0] value, input logic last);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.report_byte   <= value;
      req_bus.end_of_report <= last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      decode_report_byte(value, last);
      bytes_sent++;
   endtask

   // Split an unwrapped byte sum over at least len random bytes
   task automatic send_report(input int unsigned target, input int unsigned len);
      int unsigned n;
      int unsigned remaining;
      int unsigned rest;
      int unsigned lo;
      int unsigned hi;
      int unsigned b;
      n = (len == 0) ? 1 : len;
      if (n * 255 < target) n = (target + 254) / 255;
      remaining = target;
      for (int i = 0; i < n; i++) begin
         rest = n - 1 - i;
         lo = (remaining > rest * 255) ? remaining - rest * 255 : 0;
         hi = (remaining < 255) ? remaining : 255;
         b = $urandom_range(hi, lo);
         send_byte(BYTE_W'(b), i == n - 1);
         remaining -= b;
      end
   endtask

   // Drop valid, wait for every expected event, then let the block settle
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (events_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Receiver stall and hold-off
   // ------------------------------------------------------------------------
   initial begin
      int hold_left = 0;
      int hold_seen = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_seen != hold_serial) begin
            hold_seen = hold_serial;
            hold_left = hold_len;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Event checking
   // ------------------------------------------------------------------------
   task automatic note_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("mismatch at %0t: %s", $realtime, msg);
   endtask

   always @(posedge clock) begin
      tb_event_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (events_due.size() == 0) begin
            note_mismatch($sformatf("unexpected event pedal=%0d pressed=%0d last=%0d",
                                    rsp_bus.pedal, rsp_bus.pressed, rsp_bus.last_event));
         end else begin
            want = events_due.pop_front();
            if (rsp_bus.pedal !== want.pedal || rsp_bus.pressed !== want.pressed ||
                rsp_bus.last_event !== want.last_event)
               note_mismatch($sformatf(
                  "expected pedal=%0d pressed=%0d last=%0d, got pedal=%0d pressed=%0d last=%0d",
                  want.pedal, want.pressed, want.last_event,
                  rsp_bus.pedal, rsp_bus.pressed, rsp_bus.last_event));
         end
      end
   end

   // Watchdog: end the run after a long stretch with no transfer
   initial begin
      int quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("tb_top: FAIL");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   // Reset codes 1, 2, 4 in on_off mode
   task automatic test_on_off_directed();
      send_byte(8'h00, 1'b1);              // zero sum, nothing held
      send_byte(8'h01, 1'b1);              // press left
      send_byte(8'h00, 1'b0);
      send_byte(8'h02, 1'b1);              // release left, press middle
      send_byte(8'h03, 1'b1);              // unknown sum keeps middle held
      send_byte(8'h04, 1'b1);              // release middle, press right
      send_byte(8'hFF, 1'b0);
      send_byte(8'h01, 1'b1);              // sum 256 is unknown
      wait_idle();
   endtask

   task automatic test_override_directed();
      configure(MODE_OVERRIDE, 16'd1, 16'd2, 16'd4);
      send_report(1, 1);                   // press left
      send_report(3, 2);                   // left plus middle
      send_report(6, 1);                   // middle plus right
      send_report(5, 2);                   // left plus right
      send_report(7, 3);                   // all three: releases only
      send_report(0, 1);
      send_report(2, 1);
      wait_idle();
   endtask

   task automatic test_shared_codes();
      configure(MODE_ON_OFF, 16'd5, 16'd5, 16'd5);
      send_report(5, 2);                   // three presses, right ends held
      send_report(9, 1);
      wait_idle();
      configure(MODE_OVERRIDE, 16'd0, 16'd7, 16'd0);
      send_report(0, 1);                   // zero codes press, then nothing held
      send_report(7, 1);
      wait_idle();
   endtask

   // Codes at the top of the range; pair sums beyond the code width
   task automatic test_wide_codes();
      configure(MODE_ON_OFF, 16'hFFFF, 16'h0000, 16'h8000);
      send_report(0, 1);                   // middle code zero: press, then nothing held
      send_report(255, 1);
      wait_idle();
      configure(MODE_OVERRIDE, 16'hFFFF, 16'h0001, 16'h8000);
      send_report(0, 1);                   // left plus middle must not wrap to zero
      send_report(1, 1);
      send_report(0, 1);
      wait_idle();
   endtask

   // Hold the receiver off while reports keep coming so the block stalls its input
   task automatic test_backpressure();
      int unsigned sums[4] = '{3, 5, 6, 1};
      configure(MODE_OVERRIDE, 16'd1, 16'd2, 16'd4);
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      hold_len = 400;
      hold_serial++;
      for (int i = 0; i < 24; i++) send_report(sums[i % 4], 1);
      wait_idle();
   endtask

   function automatic logic [CODE_W-1:0] pick_code();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         default: return CODE_W'($urandom_range(200, 1));
      endcase
   endfunction

   task automatic random_report();
      int unsigned l;
      int unsigned m;
      int unsigned r;
      int unsigned target;
      l = shadow_cfg.left_code;
      m = shadow_cfg.middle_code;
      r = shadow_cfg.right_code;
      case ($urandom_range(9))
         0:       target = 0;
         1:       target = l;
         2:       target = m;
         3:       target = r;
         4:       target = l + m;
         5:       target = l + r;
         6:       target = m + r;
         7:       target = l + m + r;
         default: target = $urandom_range(1020);
      endcase
      // Keep reports short; unreachable sums become noise
      if (target > 1020) target = $urandom_range(1020);
      send_report(target, $urandom_range(4, 1));
   endtask

   task automatic test_random_reports();
      int sender_pct[4]   = '{0, 47, 0, 37};
      int receiver_pct[4] = '{0, 0, 47, 37};
      logic [CODE_W-1:0] l;
      logic [CODE_W-1:0] m;
      logic [CODE_W-1:0] r;
      int unsigned start;
      for (int phase = 0; phase < 4; phase++) begin
         for (int k = 0; k < 2; k++) begin
            l = pick_code();
            m = ($urandom_range(4) == 0) ? l : pick_code();
            r = ($urandom_range(4) == 0) ? m : pick_code();
            configure(k[0], l, m, r);
            sender_idle_pct    = sender_pct[phase];
            receiver_stall_pct = receiver_pct[phase];
            start = bytes_sent;
            while (bytes_sent - start < 18) random_report();
            wait_idle();
         end
      end
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
   endtask

   initial begin
      reset                 <= 1'b1;
      req_bus.valid         <= 1'b0;
      req_bus.report_byte   <= '0;
      req_bus.end_of_report <= 1'b0;
      csr_we                <= 1'b0;
      csr_index             <= REG_MODE;
      csr_wdata             <= '0;
      shadow_cfg     = '{mode: MODE_ON_OFF, left_code: 16'd1, middle_code: 16'd2,
                         right_code: 16'd4};
      running_sum    = '0;
      held_pedal     = ACT_NONE;
      override_prior = ACT_NONE;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_on_off_directed();
      test_override_directed();
      test_shared_codes();
      test_wide_codes();
      test_backpressure();
      test_random_reports();

      wait_idle();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && events_due.size() == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule

FILE: filelist.f
src/prd_pkg.sv
src/prd_req_if.sv
src/prd_rsp_if.sv
src/prd_front.sv
src/prd_queue.sv
src/prd_back.sv
src/pedal_report_event_decoder_core.sv
sim/tb_top.sv
